// ----- hdl/circle_canvas_rasterizer_defines.svh -----
// Assertion macros for the circle canvas rasterizer checker.
// Depends on a clk and an active-low rst_n in the scope of use.
`ifndef CIRCLE_CANVAS_RASTERIZER_DEFINES_SVH
`define CIRCLE_CANVAS_RASTERIZER_DEFINES_SVH

// hold cons in the same cycle as ante
`define CCR_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("circle canvas rasterizer check failed");

// hold cons in the cycle after ante
`define CCR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("circle canvas rasterizer check failed");

`endif

// ----- hdl/ccr_pkg.sv -----
// Shared types and codes for the circle canvas rasterizer.
// No dependencies; every other file but the defines header imports it.
package ccr_pkg;

    typedef logic [1:0]         mode_t;
    typedef logic [1:0]         status_t;
    typedef logic [1:0]         cfg_index_t;
    typedef logic [8:0]         cfg_data_t;
    typedef logic [7:0]         byte_t;
    typedef logic signed [18:0] coord_t;
    typedef logic [17:0]        radius_t;
    typedef logic [35:0]        rsq_t;

    localparam mode_t MODE_DRAW  = 2'd0;
    localparam mode_t MODE_READ  = 2'd1;
    localparam mode_t MODE_CLEAR = 2'd2;

    localparam status_t STATUS_OK      = 2'd0;
    localparam status_t STATUS_INVALID = 2'd1;
    localparam status_t STATUS_OUTSIDE = 2'd2;

    localparam cfg_index_t CFG_WIDTH      = 2'd0;
    localparam cfg_index_t CFG_HEIGHT     = 2'd1;
    localparam cfg_index_t CFG_BACKGROUND = 2'd2;

    localparam byte_t KIND_FILLED  = 8'h43;
    localparam byte_t KIND_OUTLINE = 8'h63;

    localparam cfg_data_t RESET_SIZE       = 9'd1;
    localparam byte_t     RESET_BACKGROUND = 8'd32;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_SCAN,
        ST_DRAIN,
        ST_READ,
        ST_DONE
    } state_t;

    typedef struct packed {
        coord_t cx;
        coord_t cy;
        rsq_t   r_sq;
        rsq_t   rm_sq;
        logic   rm_neg;
        logic   outline;
        logic   clear;
    } job_t;

endpackage

// ----- hdl/ccr_if.sv -----
// Channel interfaces: item input, result output, configuration write.
// Depends on ccr_pkg.
interface ccr_item_if;
    import ccr_pkg::*;
    logic    valid;
    logic    ready;
    mode_t   mode;
    byte_t   shape_kind;
    coord_t  center_x;
    coord_t  center_y;
    radius_t radius;
    byte_t   fill_char;
    byte_t   read_row;
    byte_t   read_col;
    modport source (output valid, mode, shape_kind, center_x, center_y, radius,
                    fill_char, read_row, read_col, input ready);
    modport sink (input valid, mode, shape_kind, center_x, center_y, radius,
                  fill_char, read_row, read_col, output ready);
endinterface

interface ccr_result_if;
    import ccr_pkg::*;
    logic    valid;
    logic    ready;
    status_t status;
    byte_t   pixel;
    modport source (output valid, status, pixel, input ready);
    modport sink (input valid, status, pixel, output ready);
endinterface

interface ccr_cfg_if;
    import ccr_pkg::*;
    logic       valid;
    logic       ready;
    cfg_index_t index;
    cfg_data_t  data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ----- hdl/ccr_dist.sv -----
// Three-stage squared-distance test: offsets, squares, sum and compare.
// Depends on ccr_pkg; drives the canvas write enable and address.
module ccr_dist #(
    parameter int IDX_W     = 8,
    parameter int ADDR_W    = 16,
    parameter int FRAC_BITS = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                issue,
    input  logic [IDX_W-1:0]    row,
    input  logic [IDX_W-1:0]    col,
    input  logic [ADDR_W-1:0]   addr,
    input  ccr_pkg::job_t       job,
    output logic                wr_en,
    output logic [ADDR_W-1:0]   wr_addr,
    output logic                busy
);
    import ccr_pkg::*;

    localparam int POS_W = IDX_W + FRAC_BITS;
    localparam int DX_W  = ((POS_W + 1 > 19) ? POS_W + 1 : 19) + 1;
    localparam int SQ_W  = 2 * DX_W;
    localparam int D2_W  = SQ_W + 1;

    logic [POS_W-1:0]       px;
    logic [POS_W-1:0]       py;
    logic signed [DX_W-1:0] dx_next;
    logic signed [DX_W-1:0] dy_next;
    logic signed [DX_W-1:0] dx_reg;
    logic signed [DX_W-1:0] dy_reg;
    logic [SQ_W-1:0]        dx2_reg;
    logic [SQ_W-1:0]        dy2_reg;
    logic [D2_W-1:0]        d2;
    logic                   cov;
    logic                   v1_reg;
    logic                   v2_reg;
    logic                   v3_reg;
    logic [ADDR_W-1:0]      a1_reg;
    logic [ADDR_W-1:0]      a2_reg;
    logic [ADDR_W-1:0]      a3_reg;

    assign px      = POS_W'(col) << FRAC_BITS;
    assign py      = POS_W'(row) << FRAC_BITS;
    assign dx_next = $signed({{(DX_W - POS_W){1'b0}}, px}) - DX_W'(job.cx);
    assign dy_next = $signed({{(DX_W - POS_W){1'b0}}, py}) - DX_W'(job.cy);

    assign d2  = D2_W'(dx2_reg) + D2_W'(dy2_reg);
    assign cov = job.clear ||
                 ((d2 <= D2_W'(job.r_sq)) &&
                  (!job.outline || job.rm_neg || (d2 > D2_W'(job.rm_sq))));

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else begin
            v1_reg <= issue;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg && cov;
        end
    end

    always_ff @(posedge clk) begin
        dx_reg  <= dx_next;
        dy_reg  <= dy_next;
        a1_reg  <= addr;
        dx2_reg <= $unsigned(SQ_W'(dx_reg) * SQ_W'(dx_reg));
        dy2_reg <= $unsigned(SQ_W'(dy_reg) * SQ_W'(dy_reg));
        a2_reg  <= a1_reg;
        a3_reg  <= a2_reg;
    end

    assign wr_en   = v3_reg;
    assign wr_addr = a3_reg;
    assign busy    = v1_reg || v2_reg || v3_reg;

endmodule

// ----- hdl/circle_canvas_rasterizer.sv -----
// Circle canvas rasterizer: draw and clear scan the h*w pixels in use, one pixel per
// cycle, and write each covered pixel; a clear covers every pixel in use.
// A read, an invalid draw and mode three skip the scan.
// One item is in work at a time; the result register frees the output side.
// Reset clears control and restores width 1, height 1, background 32; the canvas
// memory holds no reset value and has no clearing pass.
module circle_canvas_rasterizer #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256,
    parameter int FRAC_BITS  = 8
) (
    input  logic         clk,
    input  logic         rst_n,
    ccr_cfg_if.sink      cfg,
    ccr_item_if.sink     item,
    ccr_result_if.source result
);
    import ccr_pkg::*;

    localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int MAXDIM = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
    localparam int IDX_W  = (MAXDIM > 1) ? $clog2(MAXDIM) : 1;
    localparam int CNT_W  = $clog2(MAXDIM + 1);
    localparam logic signed [18:0] ONE = 19'(1 << FRAC_BITS);

    state_t state_reg, state_next;

    cfg_data_t width_cfg_reg;
    cfg_data_t height_cfg_reg;
    byte_t     bg_reg;

    logic [CNT_W-1:0]  w_used_next, h_used_next;
    logic [CNT_W-1:0]  w_used_reg, h_used_reg;
    logic [IDX_W-1:0]  row_reg, col_reg;
    logic [ADDR_W-1:0] issue_addr;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] wr_addr;
    logic              wr_en;
    byte_t             rd_data_reg;
    byte_t             data_reg;
    radius_t           r_reg;
    job_t              job_reg;
    logic signed [18:0] rm;

    status_t res_status_reg, res_status_next;
    byte_t   res_pixel_reg;
    logic    out_valid_reg;
    status_t out_status_reg;
    byte_t   out_pixel_reg;

    logic accept;
    logic issue;
    logic load_out;
    logic col_last, row_last, scan_last;
    logic pipe_busy;
    logic draw_ok;
    logic read_in;

    byte_t canvas_mem [DEPTH];

    assign accept = item.valid && item.ready;
    assign cfg.ready = 1'b1;

    assign w_used_next = (width_cfg_reg == '0) ? CNT_W'(1) :
                         (32'(width_cfg_reg) > MAX_WIDTH) ? CNT_W'(MAX_WIDTH) :
                         CNT_W'(width_cfg_reg);
    assign h_used_next = (height_cfg_reg == '0) ? CNT_W'(1) :
                         (32'(height_cfg_reg) > MAX_HEIGHT) ? CNT_W'(MAX_HEIGHT) :
                         CNT_W'(height_cfg_reg);

    assign draw_ok = ((item.shape_kind == KIND_FILLED) ||
                      (item.shape_kind == KIND_OUTLINE)) && (item.radius != '0);
    assign read_in = (32'(item.read_row) < 32'(h_used_next)) &&
                     (32'(item.read_col) < 32'(w_used_next));

    always_comb
    begin
        res_status_next = STATUS_OK;
        case (item.mode)
            MODE_DRAW: res_status_next = draw_ok ? STATUS_OK : STATUS_INVALID;
            MODE_READ: res_status_next = read_in ? STATUS_OK : STATUS_OUTSIDE;
            default:   res_status_next = STATUS_OK;
        endcase
    end

    assign col_last  = CNT_W'(col_reg) == w_used_reg - CNT_W'(1);
    assign row_last  = CNT_W'(row_reg) == h_used_reg - CNT_W'(1);
    assign scan_last = col_last && row_last;

    assign issue_addr = ADDR_W'(32'(row_reg) * MAX_WIDTH + 32'(col_reg));
    assign rd_addr    = ADDR_W'(32'(item.read_row) * MAX_WIDTH + 32'(item.read_col));
    assign rm         = $signed({1'b0, r_reg}) - ONE;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (accept) begin
                    case (item.mode)
                        MODE_DRAW:  state_next = draw_ok ? ST_SETUP : ST_DONE;
                        MODE_READ:  state_next = ST_READ;
                        MODE_CLEAR: state_next = ST_SCAN;
                        default:    state_next = ST_DONE;
                    endcase
                end
            ST_SETUP: state_next = ST_SCAN;
            ST_SCAN:  if (scan_last) state_next = ST_DRAIN;
            ST_DRAIN: if (!pipe_busy) state_next = ST_DONE;
            ST_READ:  state_next = ST_DONE;
            ST_DONE:  if (!out_valid_reg || result.ready) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        item.ready = 1'b0;
        issue      = 1'b0;
        load_out   = 1'b0;
        case (state_reg)
            ST_IDLE: item.ready = 1'b1;
            ST_SCAN: issue = 1'b1;
            ST_DONE: load_out = !out_valid_reg || result.ready;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg      <= ST_IDLE;
            width_cfg_reg  <= RESET_SIZE;
            height_cfg_reg <= RESET_SIZE;
            bg_reg         <= RESET_BACKGROUND;
            out_valid_reg  <= 1'b0;
            row_reg        <= '0;
            col_reg        <= '0;
        end
        else begin
            state_reg <= state_next;
            if (cfg.valid && cfg.ready) begin
                case (cfg.index)
                    CFG_WIDTH:      width_cfg_reg  <= cfg.data;
                    CFG_HEIGHT:     height_cfg_reg <= cfg.data;
                    CFG_BACKGROUND: bg_reg         <= cfg.data[7:0];
                    default: ;
                endcase
            end
            if (load_out) out_valid_reg <= 1'b1;
            else if (result.ready) out_valid_reg <= 1'b0;
            if (accept) begin
                row_reg <= '0;
                col_reg <= '0;
            end
            else if (issue) begin
                if (col_last) begin
                    col_reg <= '0;
                    row_reg <= row_reg + IDX_W'(1);
                end
                else begin
                    col_reg <= col_reg + IDX_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk) begin
        if (accept) begin
            w_used_reg      <= w_used_next;
            h_used_reg      <= h_used_next;
            r_reg           <= item.radius;
            job_reg.cx      <= item.center_x;
            job_reg.cy      <= item.center_y;
            job_reg.outline <= item.shape_kind == KIND_OUTLINE;
            job_reg.clear   <= item.mode == MODE_CLEAR;
            data_reg        <= (item.mode == MODE_CLEAR) ? bg_reg : item.fill_char;
            res_status_reg  <= res_status_next;
            res_pixel_reg   <= '0;
        end
        if (state_reg == ST_SETUP) begin
            job_reg.r_sq   <= rsq_t'(r_reg) * rsq_t'(r_reg);
            job_reg.rm_neg <= rm < 0;
            job_reg.rm_sq  <= rsq_t'(rm[17:0]) * rsq_t'(rm[17:0]);
        end
        if (state_reg == ST_READ && res_status_reg == STATUS_OK)
            res_pixel_reg <= rd_data_reg;
        if (load_out) begin
            out_status_reg <= res_status_reg;
            out_pixel_reg  <= res_pixel_reg;
        end
    end

    always_ff @(posedge clk) begin
        if (wr_en) canvas_mem[wr_addr] <= data_reg;
        if (accept) rd_data_reg <= canvas_mem[rd_addr];
    end

    ccr_dist #(
        .IDX_W     (IDX_W),
        .ADDR_W    (ADDR_W),
        .FRAC_BITS (FRAC_BITS)
    ) u_dist (
        .clk     (clk),
        .rst_n   (rst_n),
        .issue   (issue),
        .row     (row_reg),
        .col     (col_reg),
        .addr    (issue_addr),
        .job     (job_reg),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .busy    (pipe_busy)
    );

    assign result.valid  = out_valid_reg;
    assign result.status = out_status_reg;
    assign result.pixel  = out_pixel_reg;

endmodule

// ----- hdl/ccr_checker.sv -----
// Port-level checks for circle_canvas_rasterizer, attached by bind.
// Depends on ccr_pkg and circle_canvas_rasterizer_defines.svh.
`include "circle_canvas_rasterizer_defines.svh"

module ccr_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_ready,
    input logic                 out_valid,
    input logic                 out_ready,
    input ccr_pkg::status_t     status,
    input ccr_pkg::byte_t       pixel
);
    import ccr_pkg::*;

    `CCR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(status) && $stable(pixel))
    `CCR_ASSERT_SAME(a_err_no_pixel, out_valid && status != STATUS_OK, pixel == '0)
    `CCR_ASSERT_SAME(a_status_code, out_valid, status == STATUS_OK || status == STATUS_INVALID || status == STATUS_OUTSIDE)
    `CCR_ASSERT_NEXT(a_one_item, in_valid && in_ready, !in_ready)

endmodule

bind circle_canvas_rasterizer ccr_checker u_ccr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (item.valid),
    .in_ready  (item.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .status    (result.status),
    .pixel     (result.pixel)
);
